[hw/rtl/vdp_pkg.sv]
package vdp_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] acc_t;
  typedef logic [1:0] variant_t;
  typedef logic [4:0] events_t;
  typedef logic [13:0] mask_t;

  localparam op_t OP_READ   = 2'd0;
  localparam op_t OP_WRITE  = 2'd1;
  localparam op_t OP_EVENTS = 2'd2;

  localparam acc_t ACC_NONE  = 2'd0;
  localparam acc_t ACC_READ  = 2'd1;
  localparam acc_t ACC_WRITE = 2'd2;

  localparam variant_t VAR_ORIGINAL = 2'd0;

  localparam int NUM_VREGS  = 11;
  localparam int VREG_IDX_W = $clog2(NUM_VREGS);

  // Status byte bit positions.
  localparam int ST_FRAME_BIT     = 7;
  localparam int ST_OVERFLOW_BIT  = 6;
  localparam int ST_COLLISION_BIT = 5;

  // Status event bit positions.
  localparam int EV_FRAME     = 0;
  localparam int EV_OVERFLOW  = 1;
  localparam int EV_COLLISION = 2;
  localparam int EV_LINE_IRQ  = 3;
  localparam int EV_SPRITE    = 4;

endpackage

[hw/rtl/vdp_in_if.sv]
interface vdp_in_if;
  import vdp_pkg::*;

  logic       valid;
  logic       ready;
  op_t        operation;
  logic       port;
  logic [7:0] write_data;
  events_t    status_events;
  logic [4:0] sprite_index;

  modport source (
    output valid, operation, port, write_data, status_events, sprite_index,
    input  ready
  );

  modport sink (
    input  valid, operation, port, write_data, status_events, sprite_index,
    output ready
  );
endinterface

[hw/rtl/vdp_out_if.sv]
interface vdp_out_if;
  import vdp_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        interrupt_request;
  acc_t        queued_access;
  logic [7:0]  vram_data;
  logic [15:0] ram_pointer;
  logic [13:0] mode_flags;
  logic [7:0]  colours;
  mask_t       name_table_mask;
  mask_t       colour_table_mask;
  mask_t       pattern_table_mask;
  mask_t       sprite_attribute_mask;
  mask_t       sprite_pattern_mask;

  modport source (
    output valid, read_data, interrupt_request, queued_access, vram_data, ram_pointer,
           mode_flags, colours, name_table_mask, colour_table_mask, pattern_table_mask,
           sprite_attribute_mask, sprite_pattern_mask,
    input  ready
  );

  modport sink (
    input  valid, read_data, interrupt_request, queued_access, vram_data, ram_pointer,
           mode_flags, colours, name_table_mask, colour_table_mask, pattern_table_mask,
           sprite_attribute_mask, sprite_pattern_mask,
    output ready
  );
endinterface

[hw/rtl/vdp_register_port.sv]
// Channel   Direction  Handshake     Carries
// in_if     in         valid/ready   bus read, bus write or events-only step
// out_if    out        valid/ready   read byte, decoded modes, masks, interrupt
// cfg       in         cfg_wr_en     chip variant
//
// One item per cycle while results are taken. The state update and the full
// decode run in the cycle the item is accepted, and the result is registered.
// The output register holds one result; while it is full and not taken, in_if.ready
// is low. Synchronous active-low reset clears all state, including the video
// registers but not the output data registers, and holds ready low.
module vdp_register_port (
  input  logic                clk,
  input  logic                rst_n,
  vdp_in_if.sink              in_if,
  vdp_out_if.source           out_if,
  input  logic                cfg_wr_en,
  input  vdp_pkg::variant_t   cfg_wr_data
);
  import vdp_pkg::*;

  variant_t variant_r;
  logic     second_byte_r, second_byte_nxt;
  logic [7:0]  latched_r, latched_nxt;
  logic [15:0] pointer_r, pointer_nxt;
  logic [7:0]  read_ahead_r, read_ahead_nxt;
  acc_t        pending_r, pending_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        line_irq_r, line_irq_nxt;
  logic        cram_sel_r, cram_sel_nxt;
  logic [7:0]  vreg_r [NUM_VREGS];
  logic [7:0]  vreg_nxt [NUM_VREGS];

  logic        out_valid_r;
  logic [7:0]  rd_nxt;
  logic        in_accept;
  logic        sega;
  logic        ext;
  logic [VREG_IDX_W-1:0] vreg_sel;
  logic [7:0]  r0;
  logic [7:0]  r1;
  logic [13:0] flags_nxt;
  mask_t       nt_nxt, ct_nxt, pt_nxt, sa_nxt, sp_nxt;
  logic        irq_nxt;

  assign sega = (variant_r != VAR_ORIGINAL);
  assign ext  = variant_r[1];

  assign in_if.ready  = rst_n && (!out_valid_r || out_if.ready);
  assign in_accept    = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;

  always_comb begin
    second_byte_nxt = second_byte_r;
    latched_nxt     = latched_r;
    pointer_nxt     = pointer_r;
    read_ahead_nxt  = read_ahead_r;
    pending_nxt     = pending_r;
    status_nxt      = status_r;
    line_irq_nxt    = line_irq_r;
    cram_sel_nxt    = cram_sel_r;
    vreg_nxt        = vreg_r;
    rd_nxt          = 8'h00;
    vreg_sel        = '0;

    // Events land before the bus access. The sprite number is recorded only if
    // overflow was clear before this item's own events.
    if (in_if.status_events[EV_SPRITE] && !status_r[ST_OVERFLOW_BIT]) begin
      status_nxt[4:0] = in_if.sprite_index;
    end
    if (in_if.status_events[EV_FRAME])     status_nxt[ST_FRAME_BIT]     = 1'b1;
    if (in_if.status_events[EV_OVERFLOW])  status_nxt[ST_OVERFLOW_BIT]  = 1'b1;
    if (in_if.status_events[EV_COLLISION]) status_nxt[ST_COLLISION_BIT] = 1'b1;
    if (in_if.status_events[EV_LINE_IRQ])  line_irq_nxt = 1'b1;

    case (in_if.operation)
      OP_READ: begin
        second_byte_nxt = 1'b0;
        if (!in_if.port) begin
          rd_nxt      = read_ahead_r;
          pending_nxt = ACC_READ;
        end else begin
          rd_nxt = status_nxt;
          status_nxt[ST_FRAME_BIT]     = 1'b0;
          status_nxt[ST_OVERFLOW_BIT]  = 1'b0;
          status_nxt[ST_COLLISION_BIT] = 1'b0;
          line_irq_nxt = 1'b0;
        end
      end
      OP_WRITE: begin
        if (!in_if.port) begin
          second_byte_nxt = 1'b0;
          read_ahead_nxt  = in_if.write_data;
          pending_nxt     = ACC_WRITE;
        end else if (!second_byte_r) begin
          latched_nxt      = in_if.write_data;
          second_byte_nxt  = 1'b1;
          pointer_nxt[7:0] = in_if.write_data;
        end else begin
          pointer_nxt[15:8] = in_if.write_data;
          second_byte_nxt   = 1'b0;
          if (in_if.write_data[7]) begin
            if (sega && in_if.write_data[6]) begin
              cram_sel_nxt = 1'b1;
            end else begin
              vreg_sel = sega ? in_if.write_data[3:0] : {1'b0, in_if.write_data[2:0]};
              if (vreg_sel < VREG_IDX_W'(NUM_VREGS)) begin
                vreg_nxt[vreg_sel] = latched_r;
              end
            end
          end else begin
            if (!in_if.write_data[6]) pending_nxt = ACC_READ;
            cram_sel_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Decode of the updated register set.
  assign r0 = vreg_nxt[0];
  assign r1 = vreg_nxt[1];

  assign flags_nxt = {sega & r0[3], sega & r0[5], sega & r0[6], sega & r0[7],
                      cram_sel_nxt, r1[0], r1[1], sega & r0[4], r1[5], ~r1[6],
                      sega & r0[2], r1[3], r0[1], r1[4]};

  // The address extensions force the lowest register bits of nt, sa and sp.
  assign nt_nxt = {vreg_nxt[2][3:1], vreg_nxt[2][0] | ext, 10'h3ff};
  assign ct_nxt = {vreg_nxt[3], 6'h3f};
  assign pt_nxt = {vreg_nxt[4][2:0], 11'h7ff};
  assign sa_nxt = {vreg_nxt[5][6:1], vreg_nxt[5][0] | ext, 7'h7f};
  assign sp_nxt = {vreg_nxt[6][2], vreg_nxt[6][1] | ext, vreg_nxt[6][0] | ext, 11'h7ff};

  assign irq_nxt = (status_nxt[ST_FRAME_BIT] && r1[5]) || (sega && r0[4] && line_irq_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r     <= VAR_ORIGINAL;
      second_byte_r <= 1'b0;
      latched_r     <= 8'h00;
      pointer_r     <= 16'h0000;
      read_ahead_r  <= 8'h00;
      pending_r     <= ACC_NONE;
      status_r      <= 8'h00;
      line_irq_r    <= 1'b0;
      cram_sel_r    <= 1'b0;
      for (int i = 0; i < NUM_VREGS; i++) vreg_r[i] <= 8'h00;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) variant_r <= cfg_wr_data;
      if (in_accept) begin
        second_byte_r <= second_byte_nxt;
        latched_r     <= latched_nxt;
        pointer_r     <= pointer_nxt;
        read_ahead_r  <= read_ahead_nxt;
        pending_r     <= pending_nxt;
        status_r      <= status_nxt;
        line_irq_r    <= line_irq_nxt;
        cram_sel_r    <= cram_sel_nxt;
        vreg_r        <= vreg_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_if.read_data             <= rd_nxt;
      out_if.interrupt_request     <= irq_nxt;
      out_if.queued_access         <= pending_nxt;
      out_if.vram_data             <= read_ahead_nxt;
      out_if.ram_pointer           <= pointer_nxt;
      out_if.mode_flags            <= flags_nxt;
      out_if.colours               <= vreg_nxt[7];
      out_if.name_table_mask       <= nt_nxt;
      out_if.colour_table_mask     <= ct_nxt;
      out_if.pattern_table_mask    <= pt_nxt;
      out_if.sprite_attribute_mask <= sa_nxt;
      out_if.sprite_pattern_mask   <= sp_nxt;
    end
  end

endmodule

[hw/rtl/vdp_checker.sv]
module vdp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input vdp_pkg::op_t        in_operation,
  input logic                in_port,
  input logic [7:0]          in_write_data,
  input logic                out_valid,
  input logic                out_ready,
  input logic [7:0]          out_read_data,
  input vdp_pkg::acc_t       out_queued_access,
  input logic [7:0]          out_vram_data,
  input vdp_pkg::mask_t      out_name_table_mask,
  input vdp_pkg::mask_t      out_pattern_table_mask
);
  import vdp_pkg::*;

  // A waiting result stays offered, its read and VRAM data unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_vram_data))
    else $error("result changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_write_zero_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation != OP_READ |=> out_read_data == 8'h00)
    else $error("read data nonzero on a non-read item");

  a_data_write_queues: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_WRITE && !in_port
    |=> out_queued_access == ACC_WRITE && out_vram_data == $past(in_write_data))
    else $error("data port write did not queue a VRAM write");

  a_mask_low_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_name_table_mask[9:0] == 10'h3ff && out_pattern_table_mask[10:0] == 11'h7ff)
    else $error("table mask low bits not filled");

endmodule

bind vdp_register_port vdp_checker u_vdp_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_if.valid),
  .in_ready               (in_if.ready),
  .in_operation           (in_if.operation),
  .in_port                (in_if.port),
  .in_write_data          (in_if.write_data),
  .out_valid              (out_if.valid),
  .out_ready              (out_if.ready),
  .out_read_data          (out_if.read_data),
  .out_queued_access      (out_if.queued_access),
  .out_vram_data          (out_if.vram_data),
  .out_name_table_mask    (out_if.name_table_mask),
  .out_pattern_table_mask (out_if.pattern_table_mask)
);
